// ----- rtl/brf_pkg.sv -----
// shared types and constants for the byte ring fifo
`default_nettype none

package brf_pkg;

  localparam int unsigned DATA_W       = 64;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned LVL_W        = 12;
  localparam int unsigned TOT_W        = 64;
  localparam int unsigned CFG_W        = 4;
  localparam int unsigned BYTES_MAX    = 8;
  localparam int unsigned MIN_CAP_LOG2 = 10;
  localparam int unsigned CFG_RESET    = 12;
  localparam int unsigned IDX_W        = 3;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_PEEK   = 2'd2,
    OP_TOTALS = 2'd3
  } brf_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } brf_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] write_data;
  } brf_in_t;

  typedef struct packed {
    logic              status;
    logic [DATA_W-1:0] read_data;
    logic [LEN_W-1:0]  moved_count;
    logic [LVL_W-1:0]  fill_level;
    logic [LVL_W-1:0]  free_space;
    logic [TOT_W-1:0]  written_total;
    logic [TOT_W-1:0]  read_total;
  } brf_out_t;

  typedef struct packed {
    logic latch;
    logic eval;
    logic wr_byte;
    logic rd_issue;
    logic commit;
    logic load_out;
  } brf_cmd_t;

  typedef struct packed {
    brf_op_t op;
    logic    ok;
    logic    last;
    logic    out_free;
  } brf_sts_t;

endpackage

`default_nettype wire

// ----- rtl/brf_ctrl.sv -----
// controller state machine: sequences one item through check, byte moves and result
`default_nettype none

module brf_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_ready,
  input  brf_pkg::brf_sts_t sts,
  output brf_pkg::brf_cmd_t cmd
);
  import brf_pkg::*;

  brf_state_t state;
  brf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        priority if (sts.op == OP_TOTALS || !sts.ok) begin
          state_next = ST_FINISH;
        end else if (sts.op == OP_WRITE) begin
          state_next = ST_WRITE;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_WRITE: begin
        cmd.wr_byte = 1'b1;
        if (sts.last) begin
          cmd.commit = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        if (sts.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read byte lands this cycle
        cmd.commit = 1'b1;
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/brf_datapath.sv -----
// datapath: byte store, pointers, totals, capacity register and result register
`default_nettype none

module brf_datapath #(
  parameter int unsigned DEPTH_LOG2 = 12
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_valid,
  input  wire [brf_pkg::CFG_W-1:0]     cfg_data,
  input  brf_pkg::brf_in_t             in_data,
  input  wire                          out_ready,
  output logic                         out_valid,
  output brf_pkg::brf_out_t            out_data,
  input  brf_pkg::brf_cmd_t            cmd,
  output brf_pkg::brf_sts_t            sts
);
  import brf_pkg::*;

  localparam int unsigned AW        = DEPTH_LOG2;
  localparam int unsigned PW        = DEPTH_LOG2 + 1;
  localparam int unsigned MEM_DEPTH = 1 << DEPTH_LOG2;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        mem_q;

  brf_in_t           item;
  logic [CFG_W-1:0]  cap_log2;
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [TOT_W-1:0]  in_total;
  logic [TOT_W-1:0]  out_total;
  logic [IDX_W-1:0]  idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_slot;
  logic [DATA_W-1:0] rdata;
  logic              rej;

  brf_op_t           op;
  logic [4:0]        lg;
  logic [PW-1:0]     cap;
  logic [AW-1:0]     cap_mask;
  logic [PW-1:0]     fill;
  logic [PW-1:0]     free;
  logic [PW:0]       fill_inc;
  logic              len_ok;
  logic              fits;
  logic [AW-1:0]     base;
  logic [AW-1:0]     addr;

  assign op = brf_op_t'(item.operation);

  // clamp capacity to the supported range
  always_comb begin
    if (cap_log2 < CFG_W'(MIN_CAP_LOG2)) begin
      lg = 5'(MIN_CAP_LOG2);
    end else if ({1'b0, cap_log2} > 5'(DEPTH_LOG2)) begin
      lg = 5'(DEPTH_LOG2);
    end else begin
      lg = {1'b0, cap_log2};
    end
  end

  assign cap      = PW'(1) << lg;
  assign cap_mask = AW'(cap - PW'(1));
  assign fill     = wr_ptr - rd_ptr;
  assign fill_inc = {1'b0, fill} + (PW + 1)'(1);
  assign free     = (fill_inc >= {1'b0, cap}) ? '0 : (cap - fill - PW'(1));

  assign len_ok = (item.length != '0) && (item.length <= LEN_W'(BYTES_MAX));
  assign fits   = (op == OP_WRITE) ? (PW'(item.length) <= free)
                                   : (PW'(item.length) <= fill);

  assign base = (op == OP_WRITE) ? wr_ptr[AW-1:0] : rd_ptr[AW-1:0];
  assign addr = (base + AW'(idx)) & cap_mask;

  assign sts.op       = op;
  assign sts.ok       = len_ok && fits;
  assign sts.last     = ({1'b0, idx} == (item.length - LEN_W'(1)));
  assign sts.out_free = !out_valid || out_ready;

  // byte store
  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      mem[addr] <= item.write_data[{idx, 3'b000} +: 8];
    end
    mem_q <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_log2 <= CFG_W'(CFG_RESET);
    end else if (cfg_valid) begin
      cap_log2 <= cfg_data;
    end
  end

  // item registers and byte gathering
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item  <= in_data;
      rdata <= '0;
      idx   <= '0;
    end else begin
      if (cmd.wr_byte || cmd.rd_issue) begin
        idx <= idx + IDX_W'(1);
      end
      if (rd_pend) begin
        rdata[{rd_slot, 3'b000} +: 8] <= mem_q;
      end
    end
    rd_slot <= idx;
    if (cmd.eval) begin
      rej <= (op != OP_TOTALS) && !(len_ok && fits);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd_issue;
    end
  end

  // pointers and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      in_total  <= '0;
      out_total <= '0;
    end else begin
      if (cmd.eval && op == OP_TOTALS) begin
        in_total  <= '0;
        out_total <= '0;
      end
      if (cmd.commit) begin
        if (op == OP_WRITE) begin
          wr_ptr   <= wr_ptr + PW'(item.length);
          in_total <= in_total + TOT_W'(item.length);
        end else if (op == OP_READ) begin
          rd_ptr    <= rd_ptr + PW'(item.length);
          out_total <= out_total + TOT_W'(item.length);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.status        <= rej;
      out_data.read_data     <= rdata;
      out_data.moved_count   <= (rej || op == OP_TOTALS) ? '0 : item.length;
      out_data.fill_level    <= LVL_W'(fill);
      out_data.free_space    <= LVL_W'(free);
      out_data.written_total <= in_total;
      out_data.read_total    <= out_total;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/byte_ring_fifo.sv -----
// top level of the byte ring fifo: controller plus datapath
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_ready   in_data   (brf_in_t)
//   out      from block out_valid / out_ready out_data  (brf_out_t)
//   cfg      to block   cfg_valid / cfg_ready cfg_data  (capacity_log2)
//
// one item at a time: a rejected item or a totals reset goes from the check to its result;
// a write first moves its bytes, a read or peek issues its byte reads and waits in a drain
// step for the last byte; the block takes the next item once the result is loaded.
// the byte store has one port pair, so bytes move one per cycle.
// the next item is accepted while the last result still waits in the output register.
// a stalled output holds the block in its result step until the result is taken.
// synchronous reset clears pointers, totals, capacity (to 12) and handshake state;
// the byte store is not cleared.
`default_nettype none

module byte_ring_fifo #(
  parameter int unsigned DEPTH_LOG2 = 12
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire [brf_pkg::CFG_W-1:0] cfg_data,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  brf_pkg::brf_in_t         in_data,
  output logic                     out_valid,
  input  wire                      out_ready,
  output brf_pkg::brf_out_t        out_data
);
  import brf_pkg::*;

  brf_cmd_t cmd;
  brf_sts_t sts;

  assign cfg_ready = 1'b1;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  brf_datapath #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

// ----- rtl/brf_checker.sv -----
// port-level checks for the byte ring fifo, bound to the top level
`default_nettype none

module brf_checker (
  input wire               clk,
  input wire               rst,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input brf_pkg::brf_out_t out_data
);
  import brf_pkg::*;

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in progress");

  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |->
      (out_data.moved_count == '0 && out_data.read_data == '0))
    else $error("rejected item carries data");

  a_totals_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.status && out_data.moved_count == '0) |->
      (out_data.written_total == '0 && out_data.read_total == '0))
    else $error("totals reset result shows nonzero totals");

  a_moved_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.moved_count <= LEN_W'(BYTES_MAX)))
    else $error("moved count above item size");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
